// ----- sv/xml_tag_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// xml tag tokenizer assertion macros
// Shared concurrent assertion forms used by the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef XML_TAG_TOKENIZER_ASSERT_SVH
`define XML_TAG_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define XTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define XTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/xtt_pkg.sv -----
// ----------------------------------------------------------------------------
// xtt_pkg
// Types, constants and sizes shared by the xml tag tokenizer modules.
// ----------------------------------------------------------------------------
package xtt_pkg;

  localparam int TAG_MAX   = 128;
  localparam int VALUE_MAX = 256;
  localparam int DEPTH_MAX = 255;

  localparam int TAG_AW  = $clog2(TAG_MAX);
  localparam int TLEN_W  = $clog2(TAG_MAX + 1);
  localparam int VAL_AW  = $clog2(VALUE_MAX);
  localparam int VLEN_W  = VAL_AW;
  localparam int DEPTH_W = $clog2(DEPTH_MAX + 1);
  localparam int CNT_W   = (TLEN_W > VLEN_W) ? TLEN_W : VLEN_W;

  // characters that steer the parser
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_CLOSE,
    KIND_SELF
  } kind_t;

  typedef enum logic [3:0] {
    M_TEXT,
    M_LT,
    M_LT_SLASH,
    M_NAME,
    M_ATTR,
    M_AFTER_SLASH,
    M_PI,
    M_BANG,
    M_BANG_DASH,
    M_DOCTYPE,
    M_COMMENT
  } mode_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_RUN,
    EM_DRAIN,
    EM_EMPTY
  } emit_state_t;

  // buffer write request from the parser
  typedef struct packed {
    logic              tag_we;
    logic [TAG_AW-1:0] tag_addr;
    logic              val_we;
    logic [VAL_AW-1:0] val_addr;
    logic [7:0]        data;
  } wr_t;

  // event descriptor handed to the readout sequencer
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        depth;
    logic [TLEN_W-1:0] tag_len;
    logic [VAL_AW-1:0] val_first;
    logic [VLEN_W-1:0] val_len;
  } ev_t;

endpackage

// ----- sv/xtt_parser.sv -----
// ----------------------------------------------------------------------------
// xtt_parser
// Byte-level markup state machine: tracks mode, depth, name and value lengths
// and trim bounds, issues buffer writes and event descriptors.
// ----------------------------------------------------------------------------
module xtt_parser import xtt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_document,
  output wr_t        wr,
  output logic       ev_start,
  output ev_t        ev
);

  mode_t              mode_r, mode_nxt;
  logic               closing_r, closing_nxt;
  logic               prevq_r, prevq_nxt;
  logic [1:0]         dash_r, dash_nxt;
  logic [TLEN_W-1:0]  tlen_r, tlen_nxt;
  logic [VLEN_W-1:0]  vlen_r, vlen_nxt;
  logic [VLEN_W-1:0]  vfirst_r, vfirst_nxt;
  logic [VLEN_W-1:0]  vend_r, vend_nxt;
  logic               vseen_r, vseen_nxt;
  logic               collect_r, collect_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               disp;
  kind_t              disp_kind;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_TEXT;
      closing_r <= 1'b0;
      prevq_r   <= 1'b0;
      dash_r    <= '0;
      tlen_r    <= '0;
      vlen_r    <= '0;
      vfirst_r  <= '0;
      vend_r    <= '0;
      vseen_r   <= 1'b0;
      collect_r <= 1'b0;
      depth_r   <= '0;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      closing_r <= closing_nxt;
      prevq_r   <= prevq_nxt;
      dash_r    <= dash_nxt;
      tlen_r    <= tlen_nxt;
      vlen_r    <= vlen_nxt;
      vfirst_r  <= vfirst_nxt;
      vend_r    <= vend_nxt;
      vseen_r   <= vseen_nxt;
      collect_r <= collect_nxt;
      depth_r   <= depth_nxt;
    end
  end

  // next state, buffer writes and event building
  always_comb begin
    logic f_start, f_name, f_attr, f_text, ws;
    logic [DEPTH_W-1:0] dinc;
    mode_nxt    = mode_r;
    closing_nxt = closing_r;
    prevq_nxt   = prevq_r;
    dash_nxt    = dash_r;
    tlen_nxt    = tlen_r;
    vlen_nxt    = vlen_r;
    vfirst_nxt  = vfirst_r;
    vend_nxt    = vend_r;
    vseen_nxt   = vseen_r;
    collect_nxt = collect_r;
    depth_nxt   = depth_r;
    f_start     = 1'b0;
    f_name      = 1'b0;
    f_attr      = 1'b0;
    f_text      = 1'b0;
    disp        = 1'b0;
    disp_kind   = KIND_OPEN;
    wr          = '0;
    wr.data     = data_byte;
    ev          = '0;
    ws = (data_byte == CH_SP) || (data_byte == CH_TAB) ||
         (data_byte == CH_LF) || (data_byte == CH_CR);

    case (mode_r)
      M_LT: begin
        if (data_byte == CH_SLASH) begin
          closing_nxt = 1'b1;
          mode_nxt    = M_LT_SLASH;
        end else begin
          f_start = 1'b1;
        end
      end
      M_LT_SLASH: f_start = 1'b1;
      M_NAME:     f_name = 1'b1;
      M_ATTR:     f_attr = 1'b1;
      M_AFTER_SLASH: begin
        mode_nxt = M_TEXT;
        f_text   = (data_byte != CH_GT);
      end
      M_PI: begin
        if (data_byte == CH_GT && prevq_r) mode_nxt = M_TEXT;
        prevq_nxt = (data_byte == CH_QM);
      end
      M_BANG: begin
        if (data_byte == CH_DASH) mode_nxt = M_BANG_DASH;
        else mode_nxt = (data_byte == CH_GT) ? M_TEXT : M_DOCTYPE;
      end
      M_BANG_DASH: begin
        if (data_byte == CH_DASH) begin
          mode_nxt = M_COMMENT;
          dash_nxt = '0;
        end else begin
          mode_nxt = (data_byte == CH_GT) ? M_TEXT : M_DOCTYPE;
        end
      end
      M_DOCTYPE: begin
        if (data_byte == CH_GT) mode_nxt = M_TEXT;
      end
      M_COMMENT: begin
        if (data_byte == CH_GT && dash_r == 2'd2) begin
          mode_nxt = M_TEXT;
          dash_nxt = '0;
        end else if (data_byte == CH_DASH) begin
          if (dash_r < 2'd2) dash_nxt = dash_r + 2'd1;
        end else begin
          dash_nxt = '0;
        end
      end
      default: begin
        mode_nxt = M_TEXT;
        f_text   = 1'b1;
      end
    endcase

    // first byte after the opening bracket
    if (f_start) begin
      if (data_byte == CH_QM) begin
        mode_nxt  = M_PI;
        prevq_nxt = 1'b1;
      end else if (data_byte == CH_BANG) begin
        mode_nxt = M_BANG;
      end else begin
        f_name = 1'b1;
      end
    end

    // tag name bytes
    if (f_name) begin
      if (data_byte == CH_GT || data_byte == CH_SLASH) begin
        f_attr = 1'b1;
      end else if (ws) begin
        mode_nxt = M_ATTR;
      end else begin
        mode_nxt = M_NAME;
        if (tlen_r < TLEN_W'(TAG_MAX)) begin
          wr.tag_we   = 1'b1;
          wr.tag_addr = TAG_AW'(tlen_r);
          tlen_nxt    = tlen_r + 1'b1;
        end
      end
    end

    // attribute area and tag end
    if (f_attr) begin
      if (data_byte == CH_GT) begin
        mode_nxt  = M_TEXT;
        disp      = 1'b1;
        disp_kind = closing_nxt ? KIND_CLOSE : KIND_OPEN;
      end else if (data_byte == CH_SLASH) begin
        mode_nxt  = M_AFTER_SLASH;
        disp      = 1'b1;
        disp_kind = KIND_SELF;
      end else begin
        mode_nxt = M_ATTR;
      end
    end

    // text content with running trim bounds
    if (f_text) begin
      if (data_byte == CH_LT) begin
        mode_nxt    = M_LT;
        closing_nxt = 1'b0;
        tlen_nxt    = '0;
      end else if (collect_r && vlen_r < VLEN_W'(VALUE_MAX - 1)) begin
        wr.val_we   = 1'b1;
        wr.val_addr = VAL_AW'(vlen_r);
        vlen_nxt    = vlen_r + 1'b1;
        if (data_byte > CH_SP) begin
          if (!vseen_r) vfirst_nxt = vlen_r;
          vseen_nxt = 1'b1;
          vend_nxt  = vlen_r + 1'b1;
        end
      end
    end

    // document ends inside a tag
    if (end_of_document && !disp &&
        (mode_nxt == M_LT || mode_nxt == M_LT_SLASH ||
         mode_nxt == M_NAME || mode_nxt == M_ATTR)) begin
      disp      = 1'b1;
      disp_kind = closing_nxt ? KIND_CLOSE : KIND_OPEN;
    end

    // event dispatch
    dinc = (depth_r < DEPTH_W'(DEPTH_MAX)) ? depth_r + 1'b1 : depth_r;
    ev.kind    = disp_kind;
    ev.tag_len = tlen_nxt;
    if (disp) begin
      case (disp_kind)
        KIND_OPEN: begin
          depth_nxt   = dinc;
          ev.depth    = 8'(dinc);
          vlen_nxt    = '0;
          vseen_nxt   = 1'b0;
          collect_nxt = 1'b1;
        end
        KIND_CLOSE: begin
          ev.depth = 8'(depth_r);
          if (vseen_nxt) begin
            ev.val_first = VAL_AW'(vfirst_nxt);
            ev.val_len   = vend_nxt - vfirst_nxt;
          end
          depth_nxt   = (depth_r != '0) ? depth_r - 1'b1 : depth_r;
          vlen_nxt    = '0;
          vseen_nxt   = 1'b0;
          collect_nxt = (depth_nxt != '0);
        end
        default: begin
          ev.depth = 8'(dinc);
        end
      endcase
    end

    // back to reset after the final byte
    if (end_of_document) begin
      mode_nxt    = M_TEXT;
      closing_nxt = 1'b0;
      prevq_nxt   = 1'b0;
      dash_nxt    = '0;
      tlen_nxt    = '0;
      vlen_nxt    = '0;
      vfirst_nxt  = '0;
      vend_nxt    = '0;
      vseen_nxt   = 1'b0;
      collect_nxt = 1'b0;
      depth_nxt   = '0;
    end

    if (!in_fire) begin
      wr.tag_we = 1'b0;
      wr.val_we = 1'b0;
    end
  end

  assign ev_start = in_fire && disp;

endmodule

// ----- sv/xtt_emitter.sv -----
// ----------------------------------------------------------------------------
// xtt_emitter
// Tag and value buffers with the readout sequencer that packs an event into
// 8-byte words behind an output register.
// ----------------------------------------------------------------------------
module xtt_emitter import xtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wr_t         wr,
  input  logic        ev_start,
  input  ev_t         ev,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_nesting_depth,
  output logic        out_part,
  output logic [63:0] out_data_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_run
);

  logic [7:0] tag_mem [TAG_MAX];
  logic [7:0] val_mem [VALUE_MAX];
  logic [7:0] tag_q_r, val_q_r;
  logic [TAG_AW-1:0] tag_raddr;
  logic [VAL_AW-1:0] val_raddr;

  emit_state_t       state_r, state_nxt;
  kind_t             kind_r;
  logic [7:0]        depth_r;
  logic [TLEN_W-1:0] tlen_r;
  logic [VAL_AW-1:0] vbase_r;
  logic [VLEN_W-1:0] vlen_r;
  logic              part_r, part_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;

  // read pipeline, one byte in flight
  logic              rv_r, rv_nxt;
  logic [2:0]        rlane_r, rlane_nxt;
  logic              rlastw_r, rlastw_nxt;
  logic              rlastrun_r, rlastrun_nxt;
  logic              rpart_r, rpart_nxt;

  logic [63:0]       asm_r, asm_nxt;
  logic              pend_r, pend_nxt;
  logic [63:0]       pword_r, pword_nxt;
  logic [3:0]        pcnt_r, pcnt_nxt;
  logic              plast_r, plast_nxt;
  logic              ppart_r, ppart_nxt;

  logic              ov_r, ov_nxt;
  kind_t             okind_r, okind_nxt;
  logic [7:0]        odepth_r, odepth_nxt;
  logic              opart_r, opart_nxt;
  logic [63:0]       oword_r, oword_nxt;
  logic [3:0]        ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;

  logic              out_free;
  logic              issue;
  logic [CNT_W-1:0]  len_cur;
  logic [CNT_W-1:0]  pos_inc;
  logic              end_part;
  logic [7:0]        rbyte;
  logic [63:0]       full_word;

  // buffer memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr.tag_we) tag_mem[wr.tag_addr] <= wr.data;
    tag_q_r <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.val_we) val_mem[wr.val_addr] <= wr.data;
    val_q_r <= val_mem[val_raddr];
  end

  // event descriptor latch
  always_ff @(posedge clk) begin
    if (ev_start) begin
      kind_r  <= ev.kind;
      depth_r <= ev.depth;
      tlen_r  <= ev.tag_len;
      vbase_r <= ev.val_first;
      vlen_r  <= ev.val_len;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      rv_r    <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    part_r     <= part_nxt;
    pos_r      <= pos_nxt;
    rlane_r    <= rlane_nxt;
    rlastw_r   <= rlastw_nxt;
    rlastrun_r <= rlastrun_nxt;
    rpart_r    <= rpart_nxt;
    asm_r      <= asm_nxt;
    pword_r    <= pword_nxt;
    pcnt_r     <= pcnt_nxt;
    plast_r    <= plast_nxt;
    ppart_r    <= ppart_nxt;
    okind_r    <= okind_nxt;
    odepth_r   <= odepth_nxt;
    opart_r    <= opart_nxt;
    oword_r    <= oword_nxt;
    ocnt_r     <= ocnt_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_free  = !ov_r || !out_stall;
  assign len_cur   = part_r ? CNT_W'(vlen_r) : CNT_W'(tlen_r);
  assign pos_inc   = pos_r + 1'b1;
  assign end_part  = (pos_inc == len_cur);
  assign issue     = (state_r == EM_RUN) && !pend_r && !(rv_r && rlastw_r);
  assign tag_raddr = TAG_AW'(pos_r);
  assign val_raddr = vbase_r + VAL_AW'(pos_r);
  assign rbyte     = rpart_r ? val_q_r : tag_q_r;
  assign full_word = ((rlane_r == 3'd0) ? 64'd0 : asm_r) |
                     (64'(rbyte) << {rlane_r, 3'b000});

  // sequencer, word assembly and output register
  always_comb begin
    state_nxt    = state_r;
    part_nxt     = part_r;
    pos_nxt      = pos_r;
    rv_nxt       = 1'b0;
    rlane_nxt    = rlane_r;
    rlastw_nxt   = rlastw_r;
    rlastrun_nxt = rlastrun_r;
    rpart_nxt    = rpart_r;
    asm_nxt      = asm_r;
    pend_nxt     = pend_r;
    pword_nxt    = pword_r;
    pcnt_nxt     = pcnt_r;
    plast_nxt    = plast_r;
    ppart_nxt    = ppart_r;
    ov_nxt       = ov_r;
    okind_nxt    = okind_r;
    odepth_nxt   = odepth_r;
    opart_nxt    = opart_r;
    oword_nxt    = oword_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;

    // transfer out frees the register
    if (out_free) ov_nxt = 1'b0;

    case (state_r)
      EM_IDLE: begin
        if (ev_start) begin
          part_nxt  = (ev.tag_len == '0);
          pos_nxt   = '0;
          state_nxt = (ev.tag_len == '0 && ev.val_len == '0) ? EM_EMPTY : EM_RUN;
        end
      end
      EM_RUN: begin
        if (issue) begin
          rv_nxt       = 1'b1;
          rlane_nxt    = pos_r[2:0];
          rlastw_nxt   = end_part || (pos_r[2:0] == 3'd7);
          rlastrun_nxt = end_part && (part_r || vlen_r == '0);
          rpart_nxt    = part_r;
          if (end_part) begin
            if (!part_r && vlen_r != '0) begin
              part_nxt = 1'b1;
              pos_nxt  = '0;
            end else begin
              state_nxt = EM_DRAIN;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      EM_DRAIN: begin
        if (!rv_r && !pend_r) state_nxt = EM_IDLE;
      end
      EM_EMPTY: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = kind_r;
          odepth_nxt = depth_r;
          opart_nxt  = 1'b0;
          oword_nxt  = '0;
          ocnt_nxt   = '0;
          olast_nxt  = 1'b1;
          state_nxt  = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase

    // returning byte lands in its lane
    if (rv_r) begin
      asm_nxt = full_word;
      if (rlastw_r) begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = kind_r;
          odepth_nxt = depth_r;
          opart_nxt  = rpart_r;
          oword_nxt  = full_word;
          ocnt_nxt   = {1'b0, rlane_r} + 4'd1;
          olast_nxt  = rlastrun_r;
        end else begin
          pend_nxt  = 1'b1;
          pword_nxt = full_word;
          pcnt_nxt  = {1'b0, rlane_r} + 4'd1;
          plast_nxt = rlastrun_r;
          ppart_nxt = rpart_r;
        end
      end
    end

    // held word moves out once the register frees
    if (pend_r && out_free) begin
      pend_nxt   = 1'b0;
      ov_nxt     = 1'b1;
      okind_nxt  = kind_r;
      odepth_nxt = depth_r;
      opart_nxt  = ppart_r;
      oword_nxt  = pword_r;
      ocnt_nxt   = pcnt_r;
      olast_nxt  = plast_r;
    end
  end

  assign busy              = (state_r != EM_IDLE);
  assign out_valid         = ov_r;
  assign out_event_kind    = okind_r;
  assign out_nesting_depth = odepth_r;
  assign out_part          = opart_r;
  assign out_data_word     = oword_r;
  assign out_byte_count    = ocnt_r;
  assign out_last_of_run   = olast_r;

endmodule

// ----- sv/xml_tag_tokenizer.sv -----
// Readout: a tag-ending byte starts a word run; the event is latched, each
// byte passes the registered buffer read into its lane, and a full word moves
// into the output register. Input: one byte per cycle while the emitter is
// idle, stalled during readout: a buffer read per byte, a packing step per word.
// Reset: synchronous active-low rst_n returns the parser to text mode with
// depth 0; buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// xml_tag_tokenizer
// Streaming markup tokenizer: skips instructions, comments and attributes and
// emits open, close and self-closing tag events as runs of 8-byte words.
// ----------------------------------------------------------------------------
`include "xml_tag_tokenizer_assert.svh"

module xml_tag_tokenizer import xtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_document,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_nesting_depth,
  output logic        out_part,
  output logic [63:0] out_data_word,
  output logic [3:0]  out_byte_count,
  output logic        out_last_of_run
);

  logic in_fire;
  logic emit_busy;
  logic ev_start;
  wr_t  wr;
  ev_t  ev;

  // input held while an event is read out
  assign in_stall = emit_busy;
  assign in_fire  = in_valid && !in_stall;

  xtt_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .data_byte       (in_data_byte),
    .end_of_document (in_end_of_document),
    .wr              (wr),
    .ev_start        (ev_start),
    .ev              (ev)
  );

  xtt_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .wr                (wr),
    .ev_start          (ev_start),
    .ev                (ev),
    .busy              (emit_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_nesting_depth (out_nesting_depth),
    .out_part          (out_part),
    .out_data_word     (out_data_word),
    .out_byte_count    (out_byte_count),
    .out_last_of_run   (out_last_of_run)
  );

  // checks
  `XTT_ASSERT_NOW(a_empty_word, out_valid && out_byte_count == 4'd0, out_last_of_run && !out_part && out_data_word == 64'd0, "empty word is not a lone tag word")
  `XTT_ASSERT_NOW(a_value_close, out_valid && out_part, out_event_kind == KIND_CLOSE, "value word on a non-closing event")
  `XTT_ASSERT_NOW(a_count_range, out_valid, out_byte_count <= 4'd8, "byte count above eight")
  `XTT_ASSERT_NEXT(a_event_holds, ev_start, in_stall, "input taken during word run")

endmodule
